[rtl/core/pwbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbs_pkg
// Shared types, constants and helpers of the pulse-width bus slave.
// ----------------------------------------------------------------------------
package pwbs_pkg;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // Field widths
    localparam int ADDR_W  = 7;
    localparam int ID_W    = 8;
    localparam int SMOKE_W = 10;
    localparam int TEMP_W  = 7;
    localparam int TICK_W  = 11;
    localparam int SLOT_W  = 8;
    localparam int CODE_W  = 8;
    localparam int VAL_W   = 10;   // classified values never exceed the reset threshold

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_MODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_MODE = 2'd3;

    localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST = 7'd1;

    // Low-phase classification, in ticks
    localparam logic [TICK_W-1:0] BIT0_MIN  = 11'd5;
    localparam logic [TICK_W-1:0] BIT0_MAX  = 11'd7;
    localparam logic [TICK_W-1:0] BIT1_MIN  = 11'd10;
    localparam logic [TICK_W-1:0] BIT1_MAX  = 11'd11;
    localparam logic [TICK_W-1:0] SYNC_MIN  = 11'd15;
    localparam logic [TICK_W-1:0] SYNC_MAX  = 11'd34;
    localparam logic [TICK_W-1:0] BUS_RESET = 11'd1000;
    localparam logic [TICK_W-1:0] TICK_MAX  = 11'd2047;

    localparam logic [VAL_W-1:0] VAL_ZERO = 10'd0;
    localparam logic [VAL_W-1:0] VAL_ONE  = 10'd1;
    localparam logic [VAL_W-1:0] VAL_SYNC = 10'd2;

    // Frame slots
    localparam logic [SLOT_W-1:0] SLOT_ENUM    = 8'd2;
    localparam logic [SLOT_W-1:0] SLOT_ADDR    = 8'd8;
    localparam logic [SLOT_W-1:0] SLOT_ACK     = 8'd9;
    localparam logic [SLOT_W-1:0] SLOT_CMD     = 8'd13;
    localparam logic [SLOT_W-1:0] SLOT_ALARM   = 8'd14;
    localparam logic [SLOT_W-1:0] SLOT_ID_LO   = 8'd14;
    localparam logic [SLOT_W-1:0] SLOT_ID_HI   = 8'd21;
    localparam logic [SLOT_W-1:0] SLOT_FLAG    = 8'd30;
    localparam logic [SLOT_W-1:0] SLOT_MODE_LO = 8'd34;
    localparam logic [SLOT_W-1:0] SLOT_MODE_HI = 8'd35;
    localparam logic [SLOT_W-1:0] SLOT_EXT_LO  = 8'd36;
    localparam logic [SLOT_W-1:0] SLOT_EXT_HI  = 8'd38;
    localparam logic [SLOT_W-1:0] SLOT_HUM     = 8'd39;
    localparam logic [SLOT_W-1:0] SLOT_FACK    = 8'd45;
    localparam logic [SLOT_W-1:0] SLOT_FUPD    = 8'd46;
    localparam logic [SLOT_W-1:0] SLOT_SMK_LO  = 8'd51;
    localparam logic [SLOT_W-1:0] SLOT_SMK_HI  = 8'd56;
    localparam logic [SLOT_W-1:0] SLOT_TMP_LO  = 8'd60;
    localparam logic [SLOT_W-1:0] SLOT_TMP_HI  = 8'd66;
    localparam logic [SLOT_W-1:0] SLOT_PAT_LO  = 8'd69;
    localparam logic [SLOT_W-1:0] SLOT_PAT_HI  = 8'd75;
    localparam logic [SLOT_W-1:0] SLOT_MAX     = 8'd255;
    localparam logic [SLOT_W-1:0] SLOT_OPT_BASE  = 8'd35;  // option slots 35..38
    localparam logic [SLOT_W-1:0] SLOT_CONF_BASE = 8'd42;  // confirm slots 42..45
    localparam int FIELD_LAST = 13;                        // slots 1..13 kept as values
    localparam int OPT_N      = 4;

    // Bit index bases for the serialized reply fields
    localparam logic [SLOT_W-1:0] ID_BASE  = 8'd21;
    localparam logic [SLOT_W-1:0] SMK_BASE = 8'd59;  // smoke/4 bits 6..1 = smoke bits 8..3
    localparam logic [SLOT_W-1:0] TMP_BASE = 8'd66;
    localparam logic [SLOT_W-1:0] PAT_BASE = 8'd75;
    localparam logic [6:0]        REPLY_PATTERN = 7'd25;

    // Commands
    localparam logic [CODE_W-1:0] CMD_PING = 8'd0;
    localparam logic [CODE_W-1:0] CMD_POLL = 8'd2;
    localparam logic [CODE_W-1:0] CMD_READ = 8'd3;
    localparam logic [CODE_W-1:0] CMD_FLAG = 8'd14;

    // Reply control from the slot decoder
    typedef struct packed {
        logic pulse;       // drive reply high and set indicator
        logic strobe;      // drive reply and select high, indicator untouched
        logic data_slot;   // reply follows data_bit
        logic data_bit;
        logic flag_upd;    // external flag update slot
    } reply_ctl_t;

    // Sync pulse slots: 22, 31, ... 94
    function automatic logic is_sync_slot(input logic [SLOT_W-1:0] s);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            if (s == SLOT_W'(22 + 9 * k))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

[rtl/core/pwbs_reply.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbs_reply
// Slot decoder for an addressed frame: which reply pulses and data bits go
// out in the current slot under the current command.
// ----------------------------------------------------------------------------
module pwbs_reply (
    input  logic [pwbs_pkg::SLOT_W-1:0]  slot,
    input  logic [pwbs_pkg::CODE_W-1:0]  cmd,
    input  logic [pwbs_pkg::ID_W-1:0]    device_id,
    input  logic                         report_mode,
    input  logic                         humidity_mode,
    input  logic                         ext_flag,
    input  logic                         alarm_active,
    input  logic [pwbs_pkg::SMOKE_W-1:0] smoke_level,
    input  logic [pwbs_pkg::TEMP_W-1:0]  temperature,
    output pwbs_pkg::reply_ctl_t         ctl
);
    import pwbs_pkg::*;

    logic [SLOT_W-1:0] id_idx;
    logic [SLOT_W-1:0] smk_idx;
    logic [SLOT_W-1:0] tmp_idx;
    logic [SLOT_W-1:0] pat_idx;

    assign id_idx  = ID_BASE - slot;
    assign smk_idx = SMK_BASE - slot;
    assign tmp_idx = TMP_BASE - slot;
    assign pat_idx = PAT_BASE - slot;

    always_comb
    begin
        ctl = '0;
        ctl.pulse  = (slot == SLOT_ACK) || ((slot == SLOT_ALARM) && alarm_active)
                     || is_sync_slot(slot);
        ctl.strobe = (slot == SLOT_CMD);

        unique case (cmd) inside
            CMD_PING, CMD_POLL:
            begin
                if (slot == SLOT_CMD)
                begin
                    ctl.pulse = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (slot == SLOT_CMD)
                begin
                    ctl.pulse = 1'b1;
                end
                if (slot >= SLOT_ID_LO && slot <= SLOT_ID_HI)
                begin
                    ctl.data_slot = 1'b1;
                    ctl.data_bit  = device_id[id_idx[2:0]];
                end
                else if (slot == SLOT_FLAG)
                begin
                    ctl.data_slot = 1'b1;
                    ctl.data_bit  = ext_flag;
                end
                else if (slot >= SLOT_MODE_LO && slot <= SLOT_MODE_HI)
                begin
                    ctl.data_slot = 1'b1;
                    ctl.data_bit  = report_mode;
                end
                else if (slot >= SLOT_EXT_LO && slot <= SLOT_EXT_HI)
                begin
                    ctl.data_slot = 1'b1;
                    ctl.data_bit  = ext_flag;
                end
                else if (slot == SLOT_HUM)
                begin
                    ctl.data_slot = 1'b1;
                    ctl.data_bit  = ext_flag | humidity_mode;
                end
                else if (slot >= SLOT_SMK_LO && slot <= SLOT_SMK_HI)
                begin
                    ctl.data_slot = 1'b1;
                    ctl.data_bit  = smoke_level[smk_idx[3:0]];
                end
                else if (slot >= SLOT_TMP_LO && slot <= SLOT_TMP_HI)
                begin
                    ctl.data_slot = 1'b1;
                    ctl.data_bit  = temperature[tmp_idx[2:0]];
                end
                else if (slot >= SLOT_PAT_LO && slot <= SLOT_PAT_HI)
                begin
                    ctl.data_slot = 1'b1;
                    ctl.data_bit  = REPLY_PATTERN[pat_idx[2:0]];
                end
            end
            CMD_FLAG:
            begin
                if (slot == SLOT_CMD || slot == SLOT_FLAG || slot == SLOT_FACK)
                begin
                    ctl.pulse = 1'b1;
                end
                ctl.flag_upd = (slot == SLOT_FUPD);
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/core/pulse_width_bus_slave.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_bus_slave
// Pulse-width coded bus slave: times low phases, decodes frames, answers
// in fixed reply slots when addressed.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one line sample per tick with the sensor inputs. Every
//   transfer is one tick; each produces exactly one m_* transfer with the
//   driver levels after that tick.
//   cfg_* writes the four setup registers (own address, device ID, report
//   mode, humidity mode); cfg_ready is always high. Write only while idle.
//   m_tvalid rises in the cycle after an s_* transfer. One sample per cycle
//   is taken while the result register can drain; all decoding sits between
//   the input handshake and the single result register, and the next sample
//   is taken in the same cycle the result is taken.
//   When m_tready is low the result register holds and s_tready drops until
//   it drains; no sample is lost.
//   Reset clears the low-phase timer, slot counter, frame, enumeration
//   counter, flags and drivers, and sets own address to 1. Of the slot
//   values, only slots 1..13, 35..38 and 42..45 are stored.
// ----------------------------------------------------------------------------
module pulse_width_bus_slave (
    input  logic                             clk,
    input  logic                             rst_n,
    // line_level[0], alarm_active[1], smoke_level[11:2], temperature[18:12]
    input  logic [pwbs_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // reply_line[0], select_line[1], indicator[2]
    output logic [pwbs_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pwbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pwbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pwbs_pkg::*;

    // configuration
    logic [ADDR_W-1:0] own_address_reg;
    logic [ID_W-1:0]   device_id_reg;
    logic              report_mode_reg;
    logic              humidity_mode_reg;

    // state
    logic [TICK_W-1:0] low_ticks_reg,     low_ticks_next;
    logic [SLOT_W-1:0] slot_index_reg,    slot_index_next;
    logic [CODE_W-1:0] frame_address_reg, frame_address_next;
    logic [CODE_W-1:0] command_code_reg,  command_code_next;
    logic [CODE_W-1:0] enum_counter_reg,  enum_counter_next;
    logic              external_flag_reg, external_flag_next;
    logic              seen_high_reg,     seen_high_next;
    logic              fall_done_reg,     fall_done_next;
    logic              reply_reg,         reply_next;
    logic              select_reg,        select_next;
    logic              ind_reg,           ind_next;
    logic [VAL_W-1:0]  field_reg [1:FIELD_LAST];
    logic [OPT_N-1:0]  opt_one_reg;
    logic [OPT_N-1:0]  conf_one_reg;

    // output stage
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tvalid_reg;

    // input fields
    logic               line_level;
    logic               alarm_active;
    logic [SMOKE_W-1:0] smoke_level;
    logic [TEMP_W-1:0]  temperature;

    logic              s_acc;
    logic              rise;
    logic              fall;
    logic              is_bit0, is_bit1, is_sync, is_rst, restart;
    logic [VAL_W-1:0]  val;
    logic [SLOT_W-1:0] wr_idx;
    logic [CODE_W-1:0] fa_base, fa_hit, cc_base, cc_hit, enum_base, enum_inc;
    logic [CODE_W-1:0] addr_bits, cmd_bits;
    logic              ext_base;
    logic              match;
    logic              enum_hit;
    logic [OPT_N-1:0]  pair_one;
    reply_ctl_t        ctl;

    assign line_level   = s_tdata[0];
    assign alarm_active = s_tdata[1];
    assign smoke_level  = s_tdata[11:2];
    assign temperature  = s_tdata[18:12];

    assign s_tready  = ~m_tvalid_reg | m_tready;
    assign s_acc     = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign m_tdata   = m_tdata_reg;
    assign m_tvalid  = m_tvalid_reg;

    assign rise = line_level & ~seen_high_reg;
    assign fall = ~line_level & ~fall_done_reg;

    // low-phase classification
    assign is_bit0 = (low_ticks_reg >= BIT0_MIN) && (low_ticks_reg <= BIT0_MAX);
    assign is_bit1 = (low_ticks_reg >= BIT1_MIN) && (low_ticks_reg <= BIT1_MAX);
    assign is_sync = (low_ticks_reg >= SYNC_MIN) && (low_ticks_reg <= SYNC_MAX);
    assign is_rst  = low_ticks_reg > BUS_RESET;
    assign restart = is_sync | is_rst;

    always_comb
    begin
        if (is_bit0)
        begin
            val = VAL_ZERO;
        end
        else if (is_bit1)
        begin
            val = VAL_ONE;
        end
        else if (is_sync)
        begin
            val = VAL_SYNC;
        end
        else if (is_rst)
        begin
            val = VAL_ZERO;
        end
        else
        begin
            val = low_ticks_reg[VAL_W-1:0];  // at most the reset threshold here
        end
    end

    assign wr_idx    = restart ? '0 : slot_index_reg;
    assign fa_base   = restart ? '0 : frame_address_reg;
    assign cc_base   = restart ? '0 : command_code_reg;
    assign ext_base  = is_rst ? 1'b0 : external_flag_reg;

    // the current value is forwarded for the slot being written
    assign addr_bits = CODE_W'(field_reg[2] << 6) | CODE_W'(field_reg[3] << 5)
                     | CODE_W'(field_reg[4] << 4) | CODE_W'(field_reg[5] << 3)
                     | CODE_W'(field_reg[6] << 2) | CODE_W'(field_reg[7] << 1)
                     | CODE_W'(val);
    assign cmd_bits  = CODE_W'(field_reg[10] << 3) | CODE_W'(field_reg[11] << 2)
                     | CODE_W'(field_reg[12] << 1) | CODE_W'(val);

    assign fa_hit    = (wr_idx == SLOT_ADDR) ? (fa_base | addr_bits) : fa_base;
    assign enum_base = ((wr_idx == SLOT_ADDR) && (fa_hit == '0)) ? '0 : enum_counter_reg;
    assign match     = (fa_hit == {1'b0, own_address_reg}) && (wr_idx >= SLOT_ADDR);
    assign cc_hit    = (match && (wr_idx == SLOT_CMD)) ? (cc_base | cmd_bits) : cc_base;
    assign enum_inc  = enum_base + 8'd1;
    assign enum_hit  = (wr_idx == SLOT_ENUM) && (field_reg[1] == VAL_ONE) && (val == VAL_ZERO);
    assign pair_one  = opt_one_reg & conf_one_reg;

    pwbs_reply u_reply (
        .slot          (wr_idx),
        .cmd           (cc_hit),
        .device_id     (device_id_reg),
        .report_mode   (report_mode_reg),
        .humidity_mode (humidity_mode_reg),
        .ext_flag      (ext_base),
        .alarm_active  (alarm_active),
        .smoke_level   (smoke_level),
        .temperature   (temperature),
        .ctl           (ctl)
    );

    always_comb
    begin
        low_ticks_next     = low_ticks_reg;
        slot_index_next    = slot_index_reg;
        frame_address_next = frame_address_reg;
        command_code_next  = command_code_reg;
        enum_counter_next  = enum_counter_reg;
        external_flag_next = external_flag_reg;
        seen_high_next     = seen_high_reg;
        fall_done_next     = fall_done_reg;
        reply_next         = reply_reg;
        select_next        = select_reg;
        ind_next           = ind_reg;

        if (rise)
        begin
            frame_address_next = fa_hit;
            command_code_next  = cc_hit;
            enum_counter_next  = enum_base;
            external_flag_next = ext_base;
            if (match)
            begin
                if (ctl.pulse || ctl.strobe)
                begin
                    reply_next = 1'b1;
                end
                if (ctl.pulse)
                begin
                    ind_next = 1'b1;
                end
                if (ctl.strobe)
                begin
                    select_next = 1'b1;
                end
                if (ctl.data_slot)
                begin
                    reply_next = ctl.data_bit;
                    ind_next   = ind_next | ctl.data_bit;
                end
                if (ctl.flag_upd)
                begin
                    // pair 2 takes priority over pair 3, which takes priority over pairs 0 and 1
                    if (pair_one[2])
                    begin
                        external_flag_next = 1'b0;
                    end
                    else if (pair_one[3])
                    begin
                        external_flag_next = 1'b1;
                    end
                    else if (pair_one[0] || pair_one[1])
                    begin
                        external_flag_next = 1'b0;
                    end
                end
            end
            seen_high_next = 1'b1;
            fall_done_next = 1'b0;
            low_ticks_next = '0;
            if (enum_hit)
            begin
                enum_counter_next = enum_inc;
                if (enum_inc == {1'b0, own_address_reg})
                begin
                    frame_address_next = enum_inc;
                    reply_next         = 1'b1;
                    select_next        = 1'b1;
                end
            end
            slot_index_next = (wr_idx == SLOT_MAX) ? SLOT_MAX : wr_idx + 8'd1;
        end

        if (fall)
        begin
            reply_next     = 1'b0;
            select_next    = 1'b0;
            fall_done_next = 1'b1;
            seen_high_next = 1'b0;
        end

        // the falling tick already counts as low
        if (!line_level && low_ticks_reg != TICK_MAX)
        begin
            low_ticks_next = low_ticks_reg + 11'd1;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg   <= OWN_ADDRESS_RST;
            device_id_reg     <= '0;
            report_mode_reg   <= 1'b0;
            humidity_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_OWN_ADDRESS:   own_address_reg   <= cfg_data[ADDR_W-1:0];
                REG_DEVICE_ID:     device_id_reg     <= cfg_data[ID_W-1:0];
                REG_REPORT_MODE:   report_mode_reg   <= cfg_data[0];
                REG_HUMIDITY_MODE: humidity_mode_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_ticks_reg     <= '0;
            slot_index_reg    <= '0;
            frame_address_reg <= '0;
            command_code_reg  <= '0;
            enum_counter_reg  <= '0;
            external_flag_reg <= 1'b0;
            seen_high_reg     <= 1'b0;
            fall_done_reg     <= 1'b0;
            reply_reg         <= 1'b0;
            select_reg        <= 1'b0;
            ind_reg           <= 1'b0;
            opt_one_reg       <= '0;
            conf_one_reg      <= '0;
            for (int k = 1; k <= FIELD_LAST; k++)
            begin
                field_reg[k] <= '0;
            end
        end
        else if (s_acc)
        begin
            low_ticks_reg     <= low_ticks_next;
            slot_index_reg    <= slot_index_next;
            frame_address_reg <= frame_address_next;
            command_code_reg  <= command_code_next;
            enum_counter_reg  <= enum_counter_next;
            external_flag_reg <= external_flag_next;
            seen_high_reg     <= seen_high_next;
            fall_done_reg     <= fall_done_next;
            reply_reg         <= reply_next;
            select_reg        <= select_next;
            ind_reg           <= ind_next;
            if (rise)
            begin
                for (int k = 1; k <= FIELD_LAST; k++)
                begin
                    if (wr_idx == SLOT_W'(k))
                    begin
                        field_reg[k] <= val;
                    end
                end
                for (int k = 0; k < OPT_N; k++)
                begin
                    if (wr_idx == SLOT_OPT_BASE + SLOT_W'(k))
                    begin
                        opt_one_reg[k] <= (val == VAL_ONE);
                    end
                    if (wr_idx == SLOT_CONF_BASE + SLOT_W'(k))
                    begin
                        conf_one_reg[k] <= (val == VAL_ONE);
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_acc)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            m_tdata_reg <= {5'b0, ind_next, select_next, reply_next};
        end
    end

    // assertions
    a_edge_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(seen_high_reg && fall_done_reg))
        else $error("seen_high and fall_done both set");

    a_fall_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && !line_level && !fall_done_reg) |=> (!reply_reg && !select_reg))
        else $error("drivers not released on falling edge");

    a_ind_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ind_reg |=> ind_reg)
        else $error("indicator cleared");

    a_rise_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && rise) |=> (low_ticks_reg == '0))
        else $error("low timer not cleared on rising edge");

    a_out_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata_reg[2:0] == {ind_reg, select_reg, reply_reg}))
        else $error("result register out of step with drivers");

endmodule
